// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication");

// next-cycle implication that is checked during reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed: next-cycle implication under reset");

`endif

// ===== rtl/mlr_pkg.sv =====
// shared types and codes of the midpoint line rasterizer
// no dependencies
package mlr_pkg;

  // width of the line_width register and of the per-job pixel count
  localparam int WIDTH_BITS = 4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // control part of one queued job: a run of pixels across the line
  typedef struct packed {
    logic                  pixel_valid;
    logic                  line_done;
    logic                  spread_vertical;
    logic [WIDTH_BITS-1:0] count;
  } job_ctrl_t;

endpackage

// ===== rtl/mlr_in_if.sv =====
// input channel of the rasterizer: valid/ready with the item payload
// no dependencies
interface mlr_in_if #(
  parameter int COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (output valid, op, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/mlr_out_if.sv =====
// result channel of the rasterizer: valid/ready with one pixel per transfer
// no dependencies
interface mlr_out_if #(
  parameter int COORD_BITS = 10
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         pixel_valid;
  logic                         last;
  logic                         line_done;

  modport source (output valid, pixel_x, pixel_y, pixel_valid, last, line_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_valid, last, line_done,
                  output ready);
endinterface

// ===== rtl/midpoint_line_rasterizer.sv =====
// top level of the midpoint line rasterizer with line width
// depends on mlr_pkg, mlr_in_if, mlr_out_if, mlr_front, mlr_fifo, mlr_back
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   in_ch    | in        | valid / ready      | op, start_x, start_y, end_x, end_y
//   out_ch   | out       | valid / ready      | pixel_x, pixel_y, pixel_valid,
//            |           |                    | last, line_done
//   cfg      | in        | cfg_we (no ready)  | cfg_wdata = line_width
//
// the front end takes one item per cycle while the job queue has room
// a start item or a step with no active line yields one pixel, a step yields
// line_width (1 to 9); the output register moves one pixel per unstalled cycle
// reset is synchronous and clears control state only; there is no clearing pass
// an output stall holds the output register, the queue fills behind it, and
// in_ch.ready drops once all four queue entries are taken
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = 10,
  parameter int MAX_WIDTH  = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlr_pkg::WIDTH_BITS-1:0] cfg_wdata,
  mlr_in_if.sink                         in_ch,
  mlr_out_if.source                      out_ch
);
  import mlr_pkg::*;

  // job queue: control word plus the line pixel of the run
  localparam int QUEUE_DEPTH = 4;
  localparam int CTRL_BITS   = $bits(job_ctrl_t);
  localparam int JOB_BITS    = CTRL_BITS + 2 * COORD_BITS;

  logic                  push, pop, queue_full, queue_valid;
  job_ctrl_t             f_ctrl;
  logic [COORD_BITS-1:0] f_x, f_y;
  logic [JOB_BITS-1:0]   q_wdata, q_rdata;

  // front: octant setup on start, decision walk on step, one job per transfer
  mlr_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .queue_full (queue_full),
    .push       (push),
    .job_ctrl   (f_ctrl),
    .job_x      (f_x),
    .job_y      (f_y)
  );

  assign q_wdata = {f_ctrl, f_x, f_y};

  // decouples the front, one job per accepted item, from the back end's pixel runs
  mlr_fifo #(
    .DATA_BITS (JOB_BITS),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (q_wdata),
    .full      (queue_full),
    .pop       (pop),
    .rdata     (q_rdata),
    .not_empty (queue_valid)
  );

  // back: widens each job across the line into the output register
  mlr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (queue_valid),
    .q_pop   (pop),
    .q_ctrl  (job_ctrl_t'(q_rdata[JOB_BITS-1:2*COORD_BITS])),
    .q_x     (q_rdata[2*COORD_BITS-1:COORD_BITS]),
    .q_y     (q_rdata[COORD_BITS-1:0]),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/mlr_front.sv =====
// front end: takes items, sets up the octant, walks the decision variable
// depends on mlr_pkg and mlr_in_if; pushes one job per item into the queue
module mlr_front #(
  parameter int COORD_BITS = 10,
  parameter int MAX_WIDTH  = 9
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mlr_pkg::WIDTH_BITS-1:0]  cfg_wdata,
  mlr_in_if.sink                          in_ch,
  input  logic                            queue_full,
  output logic                            push,
  output mlr_pkg::job_ctrl_t              job_ctrl,
  output logic [COORD_BITS-1:0]           job_x,
  output logic [COORD_BITS-1:0]           job_y
);
  import mlr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 3;
  localparam int MAX_CLIP = (MAX_WIDTH > 15) ? 15 : MAX_WIDTH;
  localparam logic [WIDTH_BITS-1:0] MAX_W = WIDTH_BITS'(MAX_CLIP);

  localparam logic [1:0] DIR_POS_X = 2'd0;
  localparam logic [1:0] DIR_NEG_X = 2'd1;
  localparam logic [1:0] DIR_POS_Y = 2'd2;
  localparam logic [1:0] DIR_NEG_Y = 2'd3;

  logic [WIDTH_BITS-1:0] line_width_r;
  logic [C-1:0]          cur_x_r, cur_x_nxt;
  logic [C-1:0]          cur_y_r, cur_y_nxt;
  logic signed [D-1:0]   decision_r, decision_nxt;
  logic signed [D-1:0]   inc_np_r, inc_np_nxt;
  logic signed [D-1:0]   inc_p_r, inc_p_nxt;
  logic [C-1:0]          steps_r, steps_nxt;
  logic [1:0]            major_dir_r, major_dir_nxt;
  logic                  minor_neg_r, minor_neg_nxt;
  logic                  move_np_r, move_np_nxt;
  logic                  spread_v_r, spread_v_nxt;

  logic                  accept;
  logic signed [D-1:0]   dx, dy, adx, ady, dx2, dy2;
  logic [1:0]            s_dir;
  logic                  s_mneg, s_mnp, s_spread;
  logic signed [D-1:0]   s_steps, s_p0, s_le, s_gt;

  logic                  not_pos, move_minor;
  logic [C-1:0]          minor_step, st_x, st_y, st_steps;
  logic [WIDTH_BITS-1:0] w_eff;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = accept;

  // octant setup from the endpoint differences
  always_comb begin
    dx  = $signed({3'b000, in_ch.end_x}) - $signed({3'b000, in_ch.start_x});
    dy  = $signed({3'b000, in_ch.end_y}) - $signed({3'b000, in_ch.start_y});
    dx2 = dx <<< 1;
    dy2 = dy <<< 1;
    adx = dx[D-1] ? -dx : dx;
    ady = dy[D-1] ? -dy : dy;
    s_spread = (dx != '0 || dy != '0) && (ady <= adx);
    if (!dx[D-1]) begin
      priority if (dy < -dx) begin
        s_dir = DIR_NEG_Y; s_mneg = 1'b0; s_mnp = 1'b0;
        s_steps = -dy; s_p0 = dx2 + dy; s_le = dx2; s_gt = dx2 + dy2;
      end else if (dy[D-1]) begin
        s_dir = DIR_POS_X; s_mneg = 1'b1; s_mnp = 1'b1;
        s_steps = dx; s_p0 = dy2 + dx; s_le = dy2 + dx2; s_gt = dy2;
      end else if (dy < dx) begin
        s_dir = DIR_POS_X; s_mneg = 1'b0; s_mnp = 1'b0;
        s_steps = dx; s_p0 = dy2 - dx; s_le = dy2; s_gt = dy2 - dx2;
      end else begin
        s_dir = DIR_POS_Y; s_mneg = 1'b0; s_mnp = 1'b0;
        s_steps = dy; s_p0 = dx2 - dy; s_le = dx2; s_gt = dx2 - dy2;
      end
    end else begin
      priority if (dy > -dx) begin
        s_dir = DIR_POS_Y; s_mneg = 1'b1; s_mnp = 1'b1;
        s_steps = dy; s_p0 = dx2 + dy; s_le = dx2 + dy2; s_gt = dx2;
      end else if (!dy[D-1] && dy != '0) begin
        s_dir = DIR_NEG_X; s_mneg = 1'b0; s_mnp = 1'b0;
        s_steps = -dx; s_p0 = dy2 + dx; s_le = dy2; s_gt = dy2 + dx2;
      end else if (dy > dx) begin
        s_dir = DIR_NEG_X; s_mneg = 1'b1; s_mnp = 1'b1;
        s_steps = -dx; s_p0 = dy2 - dx; s_le = dy2 - dx2; s_gt = dy2;
      end else begin
        s_dir = DIR_NEG_Y; s_mneg = 1'b1; s_mnp = 1'b1;
        s_steps = -dy; s_p0 = dx2 - dy; s_le = dx2 - dy2; s_gt = dx2;
      end
    end
  end

  // one step of the midpoint walk
  always_comb begin
    not_pos    = decision_r[D-1] || (decision_r == '0);
    move_minor = (not_pos == move_np_r);
    minor_step = minor_neg_r ? {C{1'b1}} : C'(1);
    st_x = cur_x_r;
    st_y = cur_y_r;
    if (move_minor) begin
      if (!major_dir_r[1]) st_y = st_y + minor_step;
      else                 st_x = st_x + minor_step;
    end
    unique case (major_dir_r)
      DIR_POS_X: st_x = st_x + C'(1);
      DIR_NEG_X: st_x = st_x - C'(1);
      DIR_POS_Y: st_y = st_y + C'(1);
      DIR_NEG_Y: st_y = st_y - C'(1);
    endcase
    st_steps = steps_r - C'(1);
    priority if (line_width_r == '0) w_eff = WIDTH_BITS'(1);
    else if (line_width_r > MAX_W)   w_eff = MAX_W;
    else                             w_eff = line_width_r;
  end

  // next state and the job handed to the back end
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    decision_nxt  = decision_r;
    inc_np_nxt    = inc_np_r;
    inc_p_nxt     = inc_p_r;
    steps_nxt     = steps_r;
    major_dir_nxt = major_dir_r;
    minor_neg_nxt = minor_neg_r;
    move_np_nxt   = move_np_r;
    spread_v_nxt  = spread_v_r;
    job_ctrl      = '0;
    job_x         = '0;
    job_y         = '0;
    unique case (in_ch.op)
      OP_START: begin
        cur_x_nxt     = in_ch.start_x;
        cur_y_nxt     = in_ch.start_y;
        decision_nxt  = s_p0;
        inc_np_nxt    = s_le;
        inc_p_nxt     = s_gt;
        steps_nxt     = s_steps[C-1:0];
        major_dir_nxt = s_dir;
        minor_neg_nxt = s_mneg;
        move_np_nxt   = s_mnp;
        spread_v_nxt  = s_spread;
        job_ctrl.pixel_valid     = 1'b1;
        job_ctrl.line_done       = (s_steps[C-1:0] == '0);
        job_ctrl.spread_vertical = s_spread;
        job_ctrl.count           = WIDTH_BITS'(1);
        job_x = in_ch.start_x;
        job_y = in_ch.start_y;
      end
      OP_STEP: begin
        if (steps_r != '0) begin
          cur_x_nxt    = st_x;
          cur_y_nxt    = st_y;
          decision_nxt = decision_r + (not_pos ? inc_np_r : inc_p_r);
          steps_nxt    = st_steps;
          job_ctrl.pixel_valid     = 1'b1;
          job_ctrl.line_done       = (st_steps == '0);
          job_ctrl.spread_vertical = spread_v_r;
          job_ctrl.count           = w_eff;
          job_x = st_x;
          job_y = st_y;
        end else begin
          // no line active: a single empty result
          job_ctrl.line_done = 1'b1;
          job_ctrl.count     = WIDTH_BITS'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= WIDTH_BITS'(1);
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      decision_r   <= '0;
      inc_np_r     <= '0;
      inc_p_r      <= '0;
      steps_r      <= '0;
      major_dir_r  <= DIR_POS_X;
      minor_neg_r  <= 1'b0;
      move_np_r    <= 1'b0;
      spread_v_r   <= 1'b0;
    end else begin
      if (cfg_we) line_width_r <= cfg_wdata;
      if (accept) begin
        cur_x_r     <= cur_x_nxt;
        cur_y_r     <= cur_y_nxt;
        decision_r  <= decision_nxt;
        inc_np_r    <= inc_np_nxt;
        inc_p_r     <= inc_p_nxt;
        steps_r     <= steps_nxt;
        major_dir_r <= major_dir_nxt;
        minor_neg_r <= minor_neg_nxt;
        move_np_r   <= move_np_nxt;
        spread_v_r  <= spread_v_nxt;
      end
    end
  end

endmodule

// ===== rtl/mlr_fifo.sv =====
// small job queue between front and back end, held in flip-flops
// no dependencies
module mlr_fifo #(
  parameter int DATA_BITS = 16,
  parameter int DEPTH     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wdata,
  output logic                 full,
  input  logic                 pop,
  output logic [DATA_BITS-1:0] rdata,
  output logic                 not_empty
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [DATA_BITS-1:0] mem_r [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_BITS'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_BITS'(1);
      2'b01:   count_nxt = count_r - CNT_BITS'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/mlr_back.sv =====
// back end: expands a job into its run of pixels, one per cycle while the output is not stalled
// depends on mlr_pkg and mlr_out_if; drives the output register
module mlr_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  mlr_pkg::job_ctrl_t    q_ctrl,
  input  logic [COORD_BITS-1:0] q_x,
  input  logic [COORD_BITS-1:0] q_y,
  mlr_out_if.source             out_ch
);
  import mlr_pkg::*;

  localparam int P = COORD_BITS + 2;
  localparam int W = WIDTH_BITS;

  logic                  act_r, act_nxt;
  logic [W-1:0]          k_r, cnt_r, first_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic                  vert_r, pv_r, done_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [P-1:0]          out_x_r, out_y_r;
  logic                  out_pv_r, out_last_r, out_done_r;

  logic                  adv, last_k;
  logic [P-1:0]          ofs, px, py;

  assign adv    = act_r && (!out_valid_r || out_ch.ready);
  assign last_k = (k_r == cnt_r - W'(1));
  assign q_pop  = q_valid && (!act_r || (adv && last_k));

  // offset across the line: positive side first, then the negative side
  always_comb begin
    ofs = (k_r < first_r) ? P'(k_r) : P'(first_r) - P'(1) - P'(k_r);
    px  = {2'b00, x_r} - (vert_r ? '0 : ofs);
    py  = {2'b00, y_r} + (vert_r ? ofs : '0);
  end

  always_comb begin
    act_nxt = act_r;
    if (adv && last_k) act_nxt = 1'b0;
    if (q_pop)         act_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (adv)          out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      k_r     <= '0;
      cnt_r   <= q_ctrl.count;
      first_r <= (q_ctrl.count >> 1) + W'(1);
      x_r     <= q_x;
      y_r     <= q_y;
      vert_r  <= q_ctrl.spread_vertical;
      pv_r    <= q_ctrl.pixel_valid;
      done_r  <= q_ctrl.line_done;
    end else if (adv) begin
      k_r <= k_r + W'(1);
    end
    if (adv) begin
      out_x_r    <= px;
      out_y_r    <= py;
      out_pv_r   <= pv_r;
      out_last_r <= last_k;
      out_done_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_valid = out_pv_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.line_done   = out_done_r;

endmodule

// ===== rtl/mlr_checker.sv =====
// port-level checks on the result channel of the rasterizer
// depends on assert_macros.svh; bound to midpoint_line_rasterizer below
`include "assert_macros.svh"

module mlr_checker #(
  parameter int PIX_BITS = 12
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic [PIX_BITS-1:0] out_pixel_x,
  input logic [PIX_BITS-1:0] out_pixel_y,
  input logic                out_pixel_valid,
  input logic                out_last,
  input logic                out_line_done
);

  logic                  stalled;
  logic                  blank_ok;
  logic [2*PIX_BITS+2:0] payload;

  assign stalled  = out_valid && !out_ready;
  assign payload  = {out_pixel_x, out_pixel_y, out_pixel_valid, out_last, out_line_done};
  assign blank_ok = out_last && out_line_done && out_pixel_x == '0 && out_pixel_y == '0;

  `ASSERT_NEXT(a_valid_holds, clk, rst_n, stalled, out_valid)
  `ASSERT_NEXT(a_payload_holds, clk, rst_n, stalled, $stable(payload))
  `ASSERT_IMPLIES(a_empty_result, clk, rst_n, out_valid && !out_pixel_valid, blank_ok)
  `ASSERT_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_valid)

endmodule

bind midpoint_line_rasterizer mlr_checker #(
  .PIX_BITS (COORD_BITS + 2)
) u_mlr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_valid (out_ch.pixel_valid),
  .out_last        (out_ch.last),
  .out_line_done   (out_ch.line_done)
);

// ===== verif/midpoint_line_rasterizer_tb.sv =====
// self-checking testbench of the midpoint line rasterizer: directed table, then random runs
// depends on mlr_pkg, mlr_in_if, mlr_out_if and midpoint_line_rasterizer
module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int COORD_BITS   = 10;
  localparam int MAX_WIDTH    = 9;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_CAP    = 200;

  typedef enum logic [1:0] {DIR_POS_X, DIR_NEG_X, DIR_POS_Y, DIR_NEG_Y} major_dir_e;

  // one input item as offered on in_ch
  typedef struct packed {
    logic                  op;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
  } line_item_t;

  // one plotted pixel as seen on out_ch
  typedef struct packed {
    logic signed [COORD_BITS+1:0] pixel_x;
    logic signed [COORD_BITS+1:0] pixel_y;
    logic                         pixel_valid;
    logic                         last;
    logic                         line_done;
  } pixel_t;

  // row of the directed table; want is used only where fixed is set
  typedef struct {
    int         wid;
    line_item_t item;
    bit         fixed;
    pixel_t     want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [WIDTH_BITS-1:0] cfg_wdata;

  mlr_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  mlr_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

  midpoint_line_rasterizer #(
    .COORD_BITS(COORD_BITS),
    .MAX_WIDTH (MAX_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // line state mirrored by the predictor
  logic [COORD_BITS-1:0] line_x, line_y;
  logic signed [12:0]    decision_acc, inc_le, inc_gt;
  logic [COORD_BITS-1:0] steps_rem;
  major_dir_e            major;
  logic                  minor_neg, move_le, spread_v;
  logic [WIDTH_BITS-1:0] width_reg;

  pixel_t   pixels_due[$];
  dir_row_t dir_rows[$];

  int  err_cnt = 0;
  int  res_cnt = 0;
  int  cycle_cnt = 0;
  int  send_idle_pct = 0;
  int  rx_stall_pct = 0;
  bit  hold_rx = 1'b0;

  // clock and run-away guard
  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("midpoint_line_rasterizer verification failed");
      $finish;
    end
  end

  function automatic pixel_t make_pix(int px, int py, bit pv, bit lst, bit dn);
    pixel_t p;
    p.pixel_x     = (COORD_BITS+2)'(px);
    p.pixel_y     = (COORD_BITS+2)'(py);
    p.pixel_valid = pv;
    p.last        = lst;
    p.line_done   = dn;
    return p;
  endfunction

  // octant choice from signs and magnitudes of dx, dy; ties follow the
  // boundary rules of the algorithm (e.g. dy = dx goes to the steep group)
  function automatic void load_line(line_item_t it);
    logic signed [12:0] dx, dy, dx2, dy2, adx, ady, n_steps;
    dx  = $signed({3'b000, it.ex}) - $signed({3'b000, it.sx});
    dy  = $signed({3'b000, it.ey}) - $signed({3'b000, it.sy});
    dx2 = dx <<< 1;
    dy2 = dy <<< 1;
    if (dx >= 0) begin
      if (dy < -dx) begin
        major = DIR_NEG_Y; minor_neg = 1'b0; move_le = 1'b0;
        n_steps = -dy; decision_acc = dx2 + dy; inc_le = dx2; inc_gt = dx2 + dy2;
      end else if (dy < 0) begin
        major = DIR_POS_X; minor_neg = 1'b1; move_le = 1'b1;
        n_steps = dx; decision_acc = dy2 + dx; inc_le = dy2 + dx2; inc_gt = dy2;
      end else if (dy < dx) begin
        major = DIR_POS_X; minor_neg = 1'b0; move_le = 1'b0;
        n_steps = dx; decision_acc = dy2 - dx; inc_le = dy2; inc_gt = dy2 - dx2;
      end else begin
        major = DIR_POS_Y; minor_neg = 1'b0; move_le = 1'b0;
        n_steps = dy; decision_acc = dx2 - dy; inc_le = dx2; inc_gt = dx2 - dy2;
      end
    end else begin
      if (dy > -dx) begin
        major = DIR_POS_Y; minor_neg = 1'b1; move_le = 1'b1;
        n_steps = dy; decision_acc = dx2 + dy; inc_le = dx2 + dy2; inc_gt = dx2;
      end else if (dy > 0) begin
        major = DIR_NEG_X; minor_neg = 1'b0; move_le = 1'b0;
        n_steps = -dx; decision_acc = dy2 + dx; inc_le = dy2; inc_gt = dy2 + dx2;
      end else if (dy > dx) begin
        major = DIR_NEG_X; minor_neg = 1'b1; move_le = 1'b1;
        n_steps = -dx; decision_acc = dy2 - dx; inc_le = dy2 - dx2; inc_gt = dy2;
      end else begin
        major = DIR_NEG_Y; minor_neg = 1'b1; move_le = 1'b1;
        n_steps = -dy; decision_acc = dx2 - dy; inc_le = dx2 - dy2; inc_gt = dx2;
      end
    end
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    spread_v  = (adx != 0 || ady != 0) && (ady <= adx);
    line_x    = it.sx;
    line_y    = it.sy;
    steps_rem = n_steps[COORD_BITS-1:0];
  endfunction

  // pixels caused by one accepted item, appended to pixels_due
  function automatic void predict_pixels(line_item_t it);
    logic not_pos, move_minor, dn;
    int   w, first_n, k;
    if (it.op == OP_START) begin
      load_line(it);
      pixels_due.push_back(make_pix(int'(line_x), int'(line_y), 1'b1, 1'b1, steps_rem == 0));
      return;
    end
    // step with no active line: a blank result, nothing moves
    if (steps_rem == 0) begin
      pixels_due.push_back(make_pix(0, 0, 1'b0, 1'b1, 1'b1));
      return;
    end
    not_pos    = (decision_acc <= 0);
    move_minor = (not_pos == move_le);
    decision_acc = decision_acc + (not_pos ? inc_le : inc_gt);
    if (move_minor) begin
      if (major == DIR_POS_X || major == DIR_NEG_X)
        line_y = minor_neg ? line_y - COORD_BITS'(1) : line_y + COORD_BITS'(1);
      else
        line_x = minor_neg ? line_x - COORD_BITS'(1) : line_x + COORD_BITS'(1);
    end
    case (major)
      DIR_POS_X: line_x = line_x + COORD_BITS'(1);
      DIR_NEG_X: line_x = line_x - COORD_BITS'(1);
      DIR_POS_Y: line_y = line_y + COORD_BITS'(1);
      default:   line_y = line_y - COORD_BITS'(1);
    endcase
    steps_rem = steps_rem - COORD_BITS'(1);
    dn = (steps_rem == 0);
    // width zero acts as one, widths above the maximum saturate
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    first_n = w / 2 + 1;
    if (first_n > w) first_n = w;
    // positive group starts on the line pixel: toward +y or toward -x
    for (k = 0; k < first_n; k++) begin
      if (spread_v)
        pixels_due.push_back(make_pix(int'(line_x), int'(line_y) + k, 1'b1, k == w - 1, dn));
      else
        pixels_due.push_back(make_pix(int'(line_x) - k, int'(line_y), 1'b1, k == w - 1, dn));
    end
    // the rest goes the other way, nearest first
    for (int i = 1; k < w; i++, k++) begin
      if (spread_v)
        pixels_due.push_back(make_pix(int'(line_x), int'(line_y) - i, 1'b1, k == w - 1, dn));
      else
        pixels_due.push_back(make_pix(int'(line_x) + i, int'(line_y), 1'b1, k == w - 1, dn));
    end
  endfunction

  task automatic report(string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("mismatch: %s", msg);
  endtask

  // result side: ready changes at the falling edge, transfers are checked at the rising edge
  always @(negedge clk)
    out_ch.ready <= !hold_rx && ($urandom_range(99) >= rx_stall_pct);

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      res_cnt++;
      if (pixels_due.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", res_cnt));
      end else begin
        want = pixels_due.pop_front();
        if (out_ch.pixel_x !== want.pixel_x)
          report($sformatf("result %0d pixel_x %0d, want %0d",
                           res_cnt, out_ch.pixel_x, want.pixel_x));
        if (out_ch.pixel_y !== want.pixel_y)
          report($sformatf("result %0d pixel_y %0d, want %0d",
                           res_cnt, out_ch.pixel_y, want.pixel_y));
        if (out_ch.pixel_valid !== want.pixel_valid)
          report($sformatf("result %0d pixel_valid %b, want %b",
                           res_cnt, out_ch.pixel_valid, want.pixel_valid));
        if (out_ch.last !== want.last)
          report($sformatf("result %0d last %b, want %b", res_cnt, out_ch.last, want.last));
        if (out_ch.line_done !== want.line_done)
          report($sformatf("result %0d line_done %b, want %b",
                           res_cnt, out_ch.line_done, want.line_done));
      end
    end
  end

  // offer one item from the falling edge on, with random gaps, until the transfer
  task automatic send_item(line_item_t it, bit fixed, pixel_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= it.op;
    in_ch.start_x <= it.sx;
    in_ch.start_y <= it.sy;
    in_ch.end_x   <= it.ex;
    in_ch.end_y   <= it.ey;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_pixels(it);
    // typed-in rows override what the predictor says (exactly one result each)
    if (fixed) begin
      void'(pixels_due.pop_back());
      pixels_due.push_back(want);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // block is idle once every expected pixel has come out and the settle time passes
  task automatic drain(int settle);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_width(int w);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= WIDTH_BITS'(w);
    @(posedge clk);
    width_reg = WIDTH_BITS'(w);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void add_row(int wid, logic op, int sx, int sy, int ex, int ey,
                                  bit fixed = 1'b0, int fx = 0, int fy = 0,
                                  bit fv = 1'b0, bit fl = 1'b0, bit fd = 1'b0);
    dir_row_t r;
    r.wid     = wid;
    r.item.op = op;
    r.item.sx = COORD_BITS'(sx);
    r.item.sy = COORD_BITS'(sy);
    r.item.ex = COORD_BITS'(ex);
    r.item.ey = COORD_BITS'(ey);
    r.fixed   = fixed;
    r.want    = make_pix(fx, fy, fv, fl, fd);
    dir_rows.push_back(r);
  endfunction

  // coordinate with extra weight on the window edges
  function automatic logic [COORD_BITS-1:0] edge_coord();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return COORD_BITS'($urandom_range(0, 1023));
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(logic [COORD_BITS-1:0] b);
    int v;
    v = int'(b) + int'($urandom_range(0, 24)) - 12;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return COORD_BITS'(v);
  endfunction

  function automatic line_item_t noise_item();
    line_item_t it;
    it.op = 1'($urandom_range(0, 1));
    it.sx = COORD_BITS'($urandom_range(0, 1023));
    it.sy = COORD_BITS'($urandom_range(0, 1023));
    it.ex = COORD_BITS'($urandom_range(0, 1023));
    it.ey = COORD_BITS'($urandom_range(0, 1023));
    return it;
  endfunction

  // mostly well-formed lines: a start then a run of steps, sometimes past the end
  task automatic send_stream(int n_items);
    line_item_t it;
    int sent, span, adx, ady, n_steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        it    = noise_item();
        it.op = OP_START;
        it.sx = edge_coord();
        it.sy = edge_coord();
        if ($urandom_range(9) == 0) begin
          it.ex = COORD_BITS'($urandom_range(0, 1023));
          it.ey = COORD_BITS'($urandom_range(0, 1023));
        end else begin
          it.ex = near_coord(it.sx);
          it.ey = near_coord(it.sy);
        end
        adx  = (it.ex > it.sx) ? int'(it.ex - it.sx) : int'(it.sx - it.ex);
        ady  = (it.ey > it.sy) ? int'(it.ey - it.sy) : int'(it.sy - it.ey);
        span = (adx > ady) ? adx : ady;
        if (span > 12) span = 12;
        n_steps = $urandom_range(0, span + 2);
        send_item(it, 1'b0, '0);
        sent++;
        for (int s = 0; s < n_steps && sent < n_items; s++) begin
          it    = noise_item();
          it.op = OP_STEP;
          send_item(it, 1'b0, '0);
          sent++;
        end
      end else begin
        send_item(noise_item(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic run_phase(int w, int idle_pct, int stall_pct, int n_items);
    stop_input();
    drain(4);
    set_width(w);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    send_stream(n_items);
  endtask

  initial begin
    // every input known from time zero
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_START;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x   = '0;
    in_ch.end_y   = '0;
    out_ch.ready  = 1'b0;

    // predictor reset state
    line_x = '0; line_y = '0;
    decision_acc = '0; inc_le = '0; inc_gt = '0;
    steps_rem = '0; major = DIR_POS_X;
    minor_neg = 1'b0; move_le = 1'b0; spread_v = 1'b0;
    width_reg = WIDTH_BITS'(1);

    //      width op       sx    sy    ex    ey    typed result (x, y, valid, last, done)
    // step with no active line straight after reset, reset width
    add_row(1, OP_STEP,  1023, 1023, 1023, 1023, 1'b1, 0, 0, 1'b0, 1'b1, 1'b1);
    // zero-length lines at both corners: start pixel only, already done
    add_row(1, OP_START,    0,    0,    0,    0, 1'b1, 0, 0, 1'b1, 1'b1, 1'b1);
    add_row(1, OP_START, 1023, 1023, 1023, 1023, 1'b1, 1023, 1023, 1'b1, 1'b1, 1'b1);
    // widest run at the bottom edge goes below the window
    add_row(9, OP_START,    0,    0,    3,    0);
    add_row(9, OP_STEP,     0,    0,    0,    0);
    // leftward flat line at the top corner goes above the window
    add_row(9, OP_START, 1023, 1023, 1020, 1023);
    add_row(9, OP_STEP,     0,    0,    0,    0);
    // exact diagonal, width zero acts as one
    add_row(0, OP_START,   10,   10,   13,   13);
    add_row(0, OP_STEP,     0,    0,    0,    0);
    // tie dy = -dx on both sides, width saturates
    add_row(15, OP_START,  20,   20,   17,   23);
    add_row(15, OP_STEP,    0,    0,    0,    0);
    add_row(15, OP_START,  20,   20,   23,   17);
    add_row(15, OP_STEP,    0,    0,    0,    0);
    // down-left diagonal
    add_row(4, OP_START,   20,   20,   17,   17);
    add_row(4, OP_STEP,     0,    0,    0,    0);
    // steep up, leftward
    add_row(4, OP_START,   30,   30,   28,   35);
    add_row(4, OP_STEP,     0,    0,    0,    0);
    // vertical lines up and down, horizontal spread
    add_row(3, OP_START,   50,   50,   50,   55);
    add_row(3, OP_STEP,     0,    0,    0,    0);
    add_row(2, OP_START,   50,   50,   50,   45);
    add_row(2, OP_STEP,     0,    0,    0,    0);
    // full-window anti-diagonal
    add_row(8, OP_START,    0, 1023, 1023,    0);
    add_row(8, OP_STEP,  1023, 1023, 1023, 1023);
    // one-step line, then a step past its end
    add_row(8, OP_START,    1,    0,    0,    1);
    add_row(8, OP_STEP,     0,    0,    0,    0);
    add_row(8, OP_STEP,     0,    0,    0,    0, 1'b1, 0, 0, 1'b0, 1'b1, 1'b1);

    // reset held, then released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, width changes only while the block is idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].wid != int'(width_reg)) begin
        stop_input();
        drain(4);
        set_width(dir_rows[i].wid);
      end
      send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    end

    // random runs across widths and idling patterns
    run_phase(1, 0, 0, 40);
    run_phase(9, 48, 0, 40);
    run_phase(15, 0, 48, 40);
    run_phase(0, 12, 12, 40);
    run_phase($urandom_range(2, 8), 12, 12, 40);

    // long receiver hold-off while items keep coming, so the job queue fills
    stop_input();
    drain(4);
    set_width(9);
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    fork
      begin
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      send_stream(30);
    join

    run_phase($urandom_range(2, 8), 48, 48, 40);

    // wind down and give the verdict
    stop_input();
    drain(20);
    if (pixels_due.size() != 0)
      report($sformatf("%0d expected pixels never arrived", pixels_due.size()));
    if (err_cnt == 0) begin
      $display("midpoint_line_rasterizer verification clean");
    end else begin
      $display("midpoint_line_rasterizer verification failed");
    end
    $finish;
  end

endmodule
